// ----- src/chacha20_stream_cipher_core_assert.svh -----
// Assertion macros shared by the cipher core.
`ifndef CHACHA20_STREAM_CIPHER_CORE_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/chacha_pkg.sv -----
// Types, constants and helper functions of the ChaCha20 stream cipher core.
package chacha_pkg;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 20;
  localparam int unsigned RoundW    = $clog2(NumRounds);

  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646e;
  localparam logic [31:0] Sigma2 = 32'h7962_2d32;
  localparam logic [31:0] Sigma3 = 32'h6b20_6574;

  typedef enum logic [2:0] {
    REG_KEY_01   = 3'd0,
    REG_KEY_23   = 3'd1,
    REG_KEY_45   = 3'd2,
    REG_KEY_67   = 3'd3,
    REG_NONCE_01 = 3'd4,
    REG_NONCE_2  = 3'd5,
    REG_INIT_CTR = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } chacha_state_e;

  typedef struct packed {
    logic       latch;     // capture input byte
    logic       load;      // load working state from the initial state
    logic       round;     // run one quarter-round step on all four lanes
    logic [1:0] step;      // which of the four quarter-round steps
    logic       diag;      // diagonal round when set, column round otherwise
    logic       finish;    // add initial state, bump counter, rewind position
    logic       emit;      // write a result into the output register
    logic       emit_lat;  // result uses the captured byte instead of the input
  } chacha_cmd_t;

  typedef struct packed {
    logic block_empty;     // byte position has reached the end of the block
  } chacha_status_t;

  // Rotate left by the amount that belongs to quarter-round step s.
  function automatic logic [31:0] rotl_step(logic [31:0] x, logic [1:0] s);
    logic [31:0] r;
    case (s)
      2'd0:    r = {x[15:0], x[31:16]};
      2'd1:    r = {x[19:0], x[31:20]};
      2'd2:    r = {x[23:0], x[31:24]};
      2'd3:    r = {x[24:0], x[31:25]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

// ----- src/chacha_ctrl.sv -----
// Controller state machine: handshakes, block generation sequencing.
module chacha_ctrl import chacha_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic           s_start_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  chacha_status_t status_i,
  output chacha_cmd_t    cmd_o
);

  chacha_state_e state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [RoundW-1:0] round_q, round_d;
  logic              m_valid_q, m_valid_d;
  logic              out_free, accept, need_block, last_step;

  assign out_free   = !m_valid_q || m_ready_i;
  assign accept     = (state_q == ST_IDLE) && s_valid_i && out_free;
  assign need_block = s_start_i || status_i.block_empty;
  assign last_step  = (step_q == 2'd3) && (round_q == RoundW'(NumRounds - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && need_block) state_d = ST_ROUND;
      ST_ROUND: if (last_step) state_d = ST_FINAL;
      ST_FINAL: state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and counters
  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = accept;
    cmd_o.load     = accept && need_block;
    cmd_o.step     = step_q;
    cmd_o.diag     = round_q[0];
    step_d         = step_q;
    round_d        = round_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.emit = accept && !need_block;
        step_d     = '0;
        round_d    = '0;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        step_d      = step_q + 2'd1;
        if (step_q == 2'd3) round_d = round_q + RoundW'(1);
      end
      ST_FINAL: cmd_o.finish = 1'b1;
      ST_OUT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_lat = 1'b1;
      end
      default: ;
    endcase
    if (cmd_o.emit) m_valid_d = 1'b1;
    else if (m_ready_i) m_valid_d = 1'b0;
    else m_valid_d = m_valid_q;
  end

  assign s_ready_o = (state_q == ST_IDLE) && out_free;
  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      round_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      round_q   <= round_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

// ----- src/chacha_datapath.sv -----
// Datapath: configuration, working state, quarter-round lanes, keystream and output.
module chacha_datapath import chacha_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [63:0]    cfg_wdata_i,
  input  logic [7:0]     data_i,
  input  chacha_cmd_t    cmd_i,
  output chacha_status_t status_o,
  output logic [7:0]     out_byte_o
);

  logic [63:0] key_q [4];
  logic [63:0] nonce01_q;
  logic [31:0] nonce2_q;
  logic [31:0] ctr_q;
  logic [6:0]  pos_q;
  logic [7:0]  byte_q;
  logic [7:0]  out_q;
  logic [31:0] init_w [NumWords];
  logic [31:0] work_q [NumWords];
  logic [31:0] work_d [NumWords];
  logic [31:0] ks_q   [NumWords];
  logic [31:0] ks_word;
  logic [7:0]  ks_byte, src_byte;

  always_comb begin
    init_w[0]  = Sigma0;
    init_w[1]  = Sigma1;
    init_w[2]  = Sigma2;
    init_w[3]  = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2*i] = key_q[i][31:0];
      init_w[5 + 2*i] = key_q[i][63:32];
    end
    init_w[12] = ctr_q;
    init_w[13] = nonce01_q[31:0];
    init_w[14] = nonce01_q[63:32];
    init_w[15] = nonce2_q;
  end

  // One quarter-round step on four independent lanes.
  always_comb begin
    logic [31:0] a, b, c, d;
    work_d = work_q;
    for (int l = 0; l < 4; l++) begin
      a = work_q[l];
      b = cmd_i.diag ? work_q[4 + ((l + 1) & 3)]  : work_q[4 + l];
      c = cmd_i.diag ? work_q[8 + ((l + 2) & 3)]  : work_q[8 + l];
      d = cmd_i.diag ? work_q[12 + ((l + 3) & 3)] : work_q[12 + l];
      if (!cmd_i.step[0]) begin
        a = a + b;
        d = rotl_step(d ^ a, cmd_i.step);
      end else begin
        c = c + d;
        b = rotl_step(b ^ c, cmd_i.step);
      end
      work_d[l] = a;
      if (cmd_i.diag) begin
        work_d[4 + ((l + 1) & 3)]  = b;
        work_d[8 + ((l + 2) & 3)]  = c;
        work_d[12 + ((l + 3) & 3)] = d;
      end else begin
        work_d[4 + l]  = b;
        work_d[8 + l]  = c;
        work_d[12 + l] = d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) work_q <= init_w;
    else if (cmd_i.round) work_q <= work_d;
    if (cmd_i.finish) begin
      for (int i = 0; i < NumWords; i++) ks_q[i] <= work_q[i] + init_w[i];
    end
    if (cmd_i.latch) byte_q <= data_i;
    if (cmd_i.emit) out_q <= src_byte ^ ks_byte;
  end

  assign ks_word  = ks_q[pos_q[5:2]];
  assign ks_byte  = ks_word[{pos_q[1:0], 3'b000} +: 8];
  assign src_byte = cmd_i.emit_lat ? byte_q : data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      nonce01_q <= '0;
      nonce2_q  <= '0;
      ctr_q     <= '0;
      pos_q     <= 7'd64;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_01:   key_q[0]  <= cfg_wdata_i;
          REG_KEY_23:   key_q[1]  <= cfg_wdata_i;
          REG_KEY_45:   key_q[2]  <= cfg_wdata_i;
          REG_KEY_67:   key_q[3]  <= cfg_wdata_i;
          REG_NONCE_01: nonce01_q <= cfg_wdata_i;
          REG_NONCE_2:  nonce2_q  <= cfg_wdata_i[31:0];
          REG_INIT_CTR: ctr_q     <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        ctr_q <= ctr_q + 32'd1;
        pos_q <= '0;
      end else if (cmd_i.emit) begin
        pos_q <= pos_q + 7'd1;
      end
    end
  end

  assign status_o.block_empty = pos_q[6];
  assign out_byte_o           = out_q;

endmodule

// ----- src/chacha20_stream_cipher_core.sv -----
// Top level of the ChaCha20 (20 rounds, 96-bit nonce) byte stream cipher.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: data_byte; tuser: start
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata: out_byte
//  cfg      | in        | cfg_we_i (no back-pressure)    | cfg_idx_i, cfg_wdata_i
//
// A byte inside the current keystream block is one transaction per cycle while the
// output register is free or being drained; its result is in the output register
// in the cycle after acceptance. A byte that needs a fresh block (message start or
// block used up) goes through these steps: the accept cycle loads the working state,
// then 80 quarter-round steps (20 rounds x 4 steps, four lanes share each step),
// then the feed-forward add and then the write of the result.
// Reset leaves the block marked used up and the counter at zero; no clearing pass.
// The output register holds under back-pressure; a new byte is taken in the
// same cycle its predecessor's result is taken.
module chacha20_stream_cipher_core import chacha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] message_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] out_byte
);

  chacha_cmd_t    cmd;
  chacha_status_t status;
  logic           start_hs;   // message-start transaction accepted
  logic           out_room;   // output register empty or being drained

  // Sequencer: decides per transaction whether a new block must be made.
  chacha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_start_i (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Holds config, counter, working state, keystream block and output byte.
  chacha_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_byte_o  (m_axis_tdata)
  );

  assign start_hs = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign out_room = !m_axis_tvalid || m_axis_tready;

`include "chacha20_stream_cipher_core_assert.svh"

  // Taking input only while the output register is free or being drained.
  `CC_ASSERT_NOW(a_ready_needs_room, s_axis_tready, out_room, "ready while output blocked")
  // A message start always launches block generation and stops intake.
  `CC_ASSERT_NEXT(a_start_busy, start_hs, !s_axis_tready, "intake open after message start")
  // No result may appear in the cycle after a message start is taken.
  `CC_ASSERT_NEXT(a_start_no_early_out, start_hs, !m_axis_tvalid, "result before block was made")

endmodule

// ----- sim/tb_chacha20_stream_cipher_core.sv -----
// Self-checking stream testbench for the ChaCha20 byte cipher core.
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher_core import chacha_pkg::*;;

  localparam int          NumCfgRegs      = 7;
  localparam logic [2:0]  RegIdxNone      = 3'd7;      // index past the register file
  localparam int          BlockBytes      = 64;
  localparam int          DirRows         = 20;
  localparam int          ItemsPerSetting = 60;
  localparam int          CfgSettle       = 4;         // idle cycles before a register write
  localparam int          EndSettle       = 100;       // covers one full block latency
  localparam int          DrainLimit      = 5000;
  localparam int          LongHold        = 400;       // receiver hold-off for the fill test
  localparam int          MaxReported     = 10;
  localparam int          TimeoutNs       = 4_000_000;

  // One directed transaction, optionally preceded by a register write.
  typedef struct packed {
    logic        wr;
    logic [2:0]  idx;
    logic [63:0] val;
    logic [7:0]  data;
    logic        start;
    logic        typed;
    logic [7:0]  out;
  } dir_row_t;

  localparam logic [63:0] Ones = 64'hFFFF_FFFF_FFFF_FFFF;

  // All-zero key, nonce and counter: the first keystream bytes are 76 b8 e0 ad.
  localparam dir_row_t DirTable [DirRows] = '{
    // wr    index         value        data   start  typed  out
    '{1'b0, REG_KEY_01,   64'h0,       8'h00, 1'b0,  1'b1,  8'h76}, // block used up at reset
    '{1'b0, REG_KEY_01,   64'h0,       8'hff, 1'b0,  1'b1,  8'h47},
    '{1'b0, REG_KEY_01,   64'h0,       8'h00, 1'b0,  1'b1,  8'he0},
    '{1'b0, REG_KEY_01,   64'h0,       8'h00, 1'b0,  1'b1,  8'had},
    '{1'b0, REG_KEY_01,   64'h0,       8'ha5, 1'b0,  1'b0,  8'h00},
    '{1'b0, REG_KEY_01,   64'h0,       8'h3c, 1'b1,  1'b0,  8'h00}, // restart mid-block
    '{1'b0, REG_KEY_01,   64'h0,       8'h01, 1'b0,  1'b0,  8'h00},
    '{1'b1, REG_KEY_01,   Ones,        8'h80, 1'b0,  1'b0,  8'h00}, // key change keeps block
    '{1'b0, REG_KEY_01,   64'h0,       8'h7f, 1'b0,  1'b0,  8'h00},
    '{1'b1, REG_INIT_CTR, Ones,        8'h00, 1'b0,  1'b0,  8'h00}, // counter load keeps block
    '{1'b0, REG_KEY_01,   64'h0,       8'hff, 1'b1,  1'b0,  8'h00}, // counter at all ones
    '{1'b0, REG_KEY_01,   64'h0,       8'h00, 1'b1,  1'b0,  8'h00}, // counter wrapped to zero
    '{1'b1, RegIdxNone,   Ones,        8'h55, 1'b1,  1'b0,  8'h00}, // write must be dropped
    '{1'b1, REG_NONCE_2,  Ones,        8'haa, 1'b1,  1'b0,  8'h00}, // upper half dropped
    '{1'b1, REG_KEY_23,   Ones,        8'h11, 1'b1,  1'b0,  8'h00},
    '{1'b1, REG_KEY_45,   Ones,        8'h22, 1'b0,  1'b0,  8'h00},
    '{1'b1, REG_KEY_67,   Ones,        8'h33, 1'b1,  1'b0,  8'h00},
    '{1'b1, REG_NONCE_01, Ones,        8'h44, 1'b1,  1'b0,  8'h00},
    '{1'b0, REG_KEY_01,   64'h0,       8'hff, 1'b0,  1'b0,  8'h00},
    '{1'b0, REG_KEY_01,   64'h0,       8'h00, 1'b0,  1'b0,  8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] message_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte

  // Predictor state: register file, current keystream block, position, counter.
  logic [63:0] cfg_shadow [NumCfgRegs];
  logic [31:0] ks_words   [NumWords];
  logic [31:0] mix_w      [NumWords];
  logic [31:0] block_ctr;
  int          ks_pos;

  logic [7:0]  expected_out_bytes [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int mismatches;
  int bytes_sent;
  int msg_starts;
  int blocks_made;
  int settings_done;

  chacha20_stream_cipher_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One quarter round on the working copy of the block.
  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // Build the next keystream block from constants, key, counter and nonce,
  // then advance the counter (wraps at 32 bits) and rewind the position.
  function automatic void make_keystream_block();
    logic [31:0] init_w [NumWords];
    int i;
    init_w[0] = Sigma0;
    init_w[1] = Sigma1;
    init_w[2] = Sigma2;
    init_w[3] = Sigma3;
    for (i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = cfg_shadow[i][31:0];
      init_w[5 + 2 * i] = cfg_shadow[i][63:32];
    end
    init_w[12] = block_ctr;
    init_w[13] = cfg_shadow[REG_NONCE_01][31:0];
    init_w[14] = cfg_shadow[REG_NONCE_01][63:32];
    init_w[15] = cfg_shadow[REG_NONCE_2][31:0];
    for (i = 0; i < NumWords; i++) mix_w[i] = init_w[i];
    for (i = 0; i < NumRounds / 2; i++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (i = 0; i < NumWords; i++) ks_words[i] = init_w[i] + mix_w[i];
    block_ctr   = block_ctr + 32'd1;
    ks_pos      = 0;
    blocks_made++;
  endfunction

  // Predict the output byte of one accepted input byte.
  function automatic logic [7:0] chacha_xor_byte(input logic [7:0] data, input logic start);
    logic [31:0] word;
    if (start || ks_pos >= BlockBytes) make_keystream_block();
    word   = ks_words[ks_pos / 4];
    word   = word >> ((ks_pos % 4) * 8);
    ks_pos = ks_pos + 1;
    return data ^ word[7:0];
  endfunction

  task automatic log_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
  endtask

  // Drive a register write and mirror it into the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    logic [63:0] kept;
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    if (idx <= REG_INIT_CTR) begin
      kept = (idx == REG_NONCE_2 || idx == REG_INIT_CTR) ? {32'h0, val[31:0]} : val;
      cfg_shadow[idx] = kept;
      if (idx == REG_INIT_CTR) block_ctr = kept[31:0];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one byte after a random gap; predict its result once accepted.
  task automatic send_byte(input logic [7:0] data, input logic start,
                           input logic typed, input logic [7:0] typed_out);
    int          gap;
    logic [7:0]  predicted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = data;
    s_axis_tuser  = start;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = chacha_xor_byte(data, start);
    expected_out_bytes.push_back(typed ? typed_out : predicted);
    bytes_sent++;
    if (start) msg_starts++;
  endtask

  // Mostly well-formed messages (start byte then payload), some loose noise.
  task automatic send_message(inout int count);
    int len;
    int i;
    if ($urandom_range(99) < 85) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(BlockBytes, 200) : $urandom_range(1, 70);
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == 0, 1'b0, 8'h00);
    end else begin
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++)
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 8'h00);
    end
    count += len;
  endtask

  // Drop valid, wait for every expected result, then let the core settle.
  task automatic wait_drained(input int settle);
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_out_bytes.size() != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (settle) @(negedge clk_i);
  endtask

  // Receiver: random ready per the current profile, or a counted hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_out_bytes.size() == 0) begin
        log_mismatch("output with nothing expected", 8'h00, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== expected_out_bytes[0])
          log_mismatch("out_byte", expected_out_bytes[0], m_axis_tdata);
        void'(expected_out_bytes.pop_front());
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d results outstanding", expected_out_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          row;
    int          mode;
    int          setting;
    int          r;
    int          sent_here;
    logic [63:0] v;

    // Hold every input at a known value from time zero.
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KEY_01;
    cfg_wdata_i   = 64'h0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    hold_cycles   = 0;
    mismatches    = 0;
    bytes_sent    = 0;
    msg_starts    = 0;
    blocks_made   = 0;
    settings_done = 0;
    send_idle_pct = 18;
    recv_idle_pct = 59;

    // Reset state of the predictor: registers zero, block used up.
    for (r = 0; r < NumCfgRegs; r++) cfg_shadow[r] = 64'h0;
    for (r = 0; r < NumWords; r++) ks_words[r] = 32'h0;
    block_ctr = 32'h0;
    ks_pos    = BlockBytes;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; writes happen only once the core has gone idle.
    for (row = 0; row < DirRows; row++) begin
      if (DirTable[row].wr) begin
        wait_drained(CfgSettle);
        write_reg(DirTable[row].idx, DirTable[row].val);
        settings_done++;
      end
      send_byte(DirTable[row].data, DirTable[row].start, DirTable[row].typed, DirTable[row].out);
    end

    // Random part: three flow-control profiles, three register settings each.
    for (mode = 0; mode < 3; mode++) begin
      for (setting = 0; setting < 3; setting++) begin
        wait_drained(CfgSettle);
        send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 59 : 0;
        recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 18 : 0;
        for (r = 0; r < NumCfgRegs; r++) begin
          case ($urandom_range(3))
            0:       v = 64'h0;
            1:       v = Ones;
            default: v = {$urandom, $urandom};
          endcase
          // Start close to the counter wrap now and then.
          if (r == REG_INIT_CTR && $urandom_range(2) == 0)
            v = {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(2))};
          write_reg(3'(r), v);
        end
        if ($urandom_range(1)) write_reg(RegIdxNone, {$urandom, $urandom});
        settings_done++;

        // Stall the output for a long stretch while bytes keep coming.
        if (mode == 2 && setting == 0) begin
          @(posedge clk_i);
          hold_cycles = LongHold;
        end

        sent_here = 0;
        while (sent_here < ItemsPerSetting) send_message(sent_here);
      end
    end

    wait_drained(EndSettle);
    if (expected_out_bytes.size() != 0) begin
      $display("%0d expected results never arrived", expected_out_bytes.size());
      mismatches += expected_out_bytes.size();
    end

    $display("Covered %0d bytes, %0d message starts, %0d keystream blocks.",
             bytes_sent, msg_starts, blocks_made);
    $display("Used %0d register settings, three idle profiles and a long output stall.",
             settings_done);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
